// ===== sv/srfc_pkg.sv =====
// Shared types and constants for the serial reply frame checker.
// Used by serial_reply_frame_checker; depends on nothing else.
`timescale 1ns / 1ps

package srfc_pkg;

   // Frame delimiters.
   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] END_BYTE   = 8'h0D;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_COMMAND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_LEN  = 2'd2;

   // Register reset values.
   localparam logic [7:0] EXPECTED_ADDRESS_RESET = 8'h00;
   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'h01;
   localparam logic [7:0] MAX_PAYLOAD_LEN_RESET  = 8'hFF;

   // Closing status of a frame.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_START = 3'd1,
      STATUS_BAD_ADDR  = 3'd2,
      STATUS_BAD_CMD   = 3'd3,
      STATUS_TOO_LONG  = 3'd4,
      STATUS_BAD_SUM   = 3'd5,
      STATUS_BAD_END   = 3'd6
   } frame_status_type;

   // Receive phase, one-hot.
   typedef enum logic [3:0] {
      PHASE_HEADER   = 4'b0001,
      PHASE_PAYLOAD  = 4'b0010,
      PHASE_CHECKSUM = 4'b0100,
      PHASE_END      = 4'b1000
   } frame_phase_type;

   // Packed result data: payload byte, status, length from the lowest bit up.
   localparam int unsigned RSP_DATA_W = 24;

endpackage

// ===== sv/serial_reply_frame_checker.sv =====
// Results are registered: a result appears on the rsp_ side in the cycle after
// its item is accepted. Throughput: one item per cycle while the result register
// is empty or being taken; it frees itself in the same cycle it is taken, so the
// next item is accepted while it drains. Checksum bytes give no result; a status
// closes each frame. Reset (synchronous, active high) clears the frame state, the
// result register and loads the register defaults: address 0, command 1, length
// limit 255. Depends on srfc_pkg for constants and types.
`timescale 1ns / 1ps

module serial_reply_frame_checker (
   input  logic                               clock,
   input  logic                               reset,
   // Received bytes.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] rx_byte
   // Results.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [srfc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [7:0] payload_byte,
                                                          // [10:8] frame_status,
                                                          // [18:11] payload_len
   output logic [0:0]                         rsp_tuser,  // [0] is_status
   // Configuration writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_data
);

   // Configuration registers.
   logic [7:0] exp_addr_ff;
   logic [7:0] exp_cmd_ff;
   logic [7:0] max_len_ff;

   // Frame state.
   srfc_pkg::frame_phase_type phase_ff, phase_in;
   logic [1:0] hdr_count_ff, hdr_count_in;
   logic [7:0] start_ff, start_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] sum_ff, sum_in;
   logic       sum_bad_ff, sum_bad_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        is_status_ff, is_status_in;
   logic [7:0]                  pay_byte_ff, pay_byte_in;
   srfc_pkg::frame_status_type  status_ff, status_in;
   logic [7:0]                  pay_len_ff, pay_len_in;

   logic req_fire;
   logic emit;
   logic [7:0] rx;

   assign rx         = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = is_status_ff;
   assign rsp_tdata    = {5'd0, pay_len_ff, status_ff, pay_byte_ff};

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_addr_ff <= srfc_pkg::EXPECTED_ADDRESS_RESET;
         exp_cmd_ff  <= srfc_pkg::EXPECTED_COMMAND_RESET;
         max_len_ff  <= srfc_pkg::MAX_PAYLOAD_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srfc_pkg::CSR_EXPECTED_ADDRESS: exp_addr_ff <= csr_data;
            srfc_pkg::CSR_EXPECTED_COMMAND: exp_cmd_ff  <= csr_data;
            srfc_pkg::CSR_MAX_PAYLOAD_LEN:  max_len_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Next frame state and result for one accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      start_in     = start_ff;
      addr_in      = addr_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      xor_in       = xor_ff;
      sum_in       = sum_ff;
      sum_bad_in   = sum_bad_ff;
      emit         = 1'b0;
      is_status_in = 1'b0;
      pay_byte_in  = 8'd0;
      status_in    = srfc_pkg::STATUS_OK;
      pay_len_in   = 8'd0;

      case (phase_ff)
         srfc_pkg::PHASE_PAYLOAD: begin
            // Stream the byte out and fold it into the checksum.
            xor_in      = xor_ff ^ rx;
            sum_in      = sum_ff + rx;
            left_in     = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               phase_in = srfc_pkg::PHASE_CHECKSUM;
            end
            emit        = 1'b1;
            pay_byte_in = rx;
         end
         srfc_pkg::PHASE_CHECKSUM: begin
            sum_bad_in = (rx != (xor_ff ^ sum_ff));
            phase_in   = srfc_pkg::PHASE_END;
         end
         srfc_pkg::PHASE_END: begin
            // Close the frame; a checksum error wins over a bad end byte.
            emit         = 1'b1;
            is_status_in = 1'b1;
            pay_len_in   = len_ff;
            if (sum_bad_ff) begin
               status_in = srfc_pkg::STATUS_BAD_SUM;
            end else if (rx != srfc_pkg::END_BYTE) begin
               status_in = srfc_pkg::STATUS_BAD_END;
            end
            phase_in     = srfc_pkg::PHASE_HEADER;
            hdr_count_in = 2'd0;
            start_in     = 8'd0;
            addr_in      = 8'd0;
            cmd_in       = 8'd0;
            len_in       = 8'd0;
            left_in      = 8'd0;
            xor_in       = 8'd0;
            sum_in       = 8'd0;
            sum_bad_in   = 1'b0;
         end
         default: begin
            // Header collection; unused phase codes land here too.
            phase_in = srfc_pkg::PHASE_HEADER;
            xor_in   = xor_ff ^ rx;
            sum_in   = sum_ff + rx;
            case (hdr_count_ff)
               2'd0: begin
                  start_in     = rx;
                  hdr_count_in = 2'd1;
               end
               2'd1: begin
                  addr_in      = rx;
                  hdr_count_in = 2'd2;
               end
               2'd2: begin
                  cmd_in       = rx;
                  hdr_count_in = 2'd3;
               end
               default: begin
                  // Length byte: run the header checks in priority order.
                  len_in       = rx;
                  hdr_count_in = 2'd0;
                  if (start_ff != srfc_pkg::START_BYTE) begin
                     status_in = srfc_pkg::STATUS_BAD_START;
                  end else if (addr_ff != exp_addr_ff) begin
                     status_in = srfc_pkg::STATUS_BAD_ADDR;
                  end else if (cmd_ff != exp_cmd_ff) begin
                     status_in = srfc_pkg::STATUS_BAD_CMD;
                  end else if (rx > max_len_ff) begin
                     status_in = srfc_pkg::STATUS_TOO_LONG;
                  end
                  if (status_in != srfc_pkg::STATUS_OK) begin
                     emit         = 1'b1;
                     is_status_in = 1'b1;
                     pay_len_in   = rx;
                     start_in     = 8'd0;
                     addr_in      = 8'd0;
                     cmd_in       = 8'd0;
                     len_in       = 8'd0;
                     left_in      = 8'd0;
                     xor_in       = 8'd0;
                     sum_in       = 8'd0;
                     sum_bad_in   = 1'b0;
                  end else if (rx == 8'd0) begin
                     phase_in = srfc_pkg::PHASE_CHECKSUM;
                  end else begin
                     left_in  = rx;
                     phase_in = srfc_pkg::PHASE_PAYLOAD;
                  end
               end
            endcase
         end
      endcase

      // Result register: load on a result, drain when taken.
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= srfc_pkg::PHASE_HEADER;
         hdr_count_ff <= 2'd0;
         start_ff     <= 8'd0;
         addr_ff      <= 8'd0;
         cmd_ff       <= 8'd0;
         len_ff       <= 8'd0;
         left_ff      <= 8'd0;
         xor_ff       <= 8'd0;
         sum_ff       <= 8'd0;
         sum_bad_ff   <= 1'b0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         start_ff     <= start_in;
         addr_ff      <= addr_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         xor_ff       <= xor_in;
         sum_ff       <= sum_in;
         sum_bad_ff   <= sum_bad_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; loaded only when a new result is taken in.
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         is_status_ff <= is_status_in;
         pay_byte_ff  <= pay_byte_in;
         status_ff    <= status_in;
         pay_len_ff   <= pay_len_in;
      end
   end

   // A payload byte always produces a data result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == srfc_pkg::PHASE_PAYLOAD |=> rsp_valid_ff && !is_status_ff)
      else $error("payload byte did not produce a data result");

   // The checksum byte moves the frame to the end phase.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == srfc_pkg::PHASE_CHECKSUM |=> phase_ff == srfc_pkg::PHASE_END)
      else $error("checksum byte did not advance to end phase");

   // The end byte closes the frame with a status and rearms header collection.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == srfc_pkg::PHASE_END
      |=> rsp_valid_ff && is_status_ff && phase_ff == srfc_pkg::PHASE_HEADER
          && hdr_count_ff == 2'd0)
      else $error("end byte did not close the frame");

   // While payload is streaming, at least one byte is still owed.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == srfc_pkg::PHASE_PAYLOAD |-> left_ff != 8'd0)
      else $error("payload phase with no bytes left");

   // A status result never carries a payload byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && is_status_ff |-> pay_byte_ff == 8'd0)
      else $error("status result carries payload data");

endmodule

// ===== tb/tb_serial_reply_frame_checker.sv =====
// Self-checking testbench for serial_reply_frame_checker: streams reply frames
// in, predicts every payload item and closing status, and checks each result.
// Depends on srfc_pkg and the serial_reply_frame_checker RTL.
`timescale 1ns / 1ps

module tb_serial_reply_frame_checker;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;

   // One result item as the block should present it.
   typedef struct {
      logic                       is_status;
      logic [7:0]                 payload_byte;
      srfc_pkg::frame_status_type status;
      logic [7:0]                 length;
   } reply_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = 8'h00;  // [7:0] rx_byte
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [srfc_pkg::RSP_DATA_W-1:0]  rsp_tdata;           // [7:0] payload_byte,
                                                          // [10:8] frame_status,
                                                          // [18:11] payload_len
   logic [0:0]                       rsp_tuser;           // [0] is_status
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [srfc_pkg::CSR_INDEX_W-1:0] csr_index  = srfc_pkg::CSR_EXPECTED_ADDRESS;
   logic [7:0]                       csr_data   = 8'h00;

   // Stimulus and handshake control.
   logic [7:0] rx_pending[$];
   int         bytes_queued  = 0;
   int         bytes_taken   = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_token    = 0;
   int         hold_seen     = 0;
   int         hold_left     = 0;
   logic       req_taken     = 1'b0;

   // Predicted frame state and register copies.
   srfc_pkg::frame_phase_type rx_phase     = srfc_pkg::PHASE_HEADER;
   int                        hdr_index    = 0;
   logic [7:0]                hdr_start    = 8'h00;
   logic [7:0]                hdr_addr     = 8'h00;
   logic [7:0]                hdr_cmd      = 8'h00;
   logic [7:0]                frame_len    = 8'h00;
   logic [7:0]                payload_left = 8'h00;
   logic [7:0]                run_xor      = 8'h00;
   logic [7:0]                run_sum      = 8'h00;
   logic                      sum_mismatch = 1'b0;
   logic [7:0]                want_addr    = srfc_pkg::EXPECTED_ADDRESS_RESET;
   logic [7:0]                want_cmd     = srfc_pkg::EXPECTED_COMMAND_RESET;
   logic [7:0]                len_limit    = srfc_pkg::MAX_PAYLOAD_LEN_RESET;

   reply_type expected_replies[$];
   reply_type head_reply;
   int        mismatches    = 0;
   int        idle_cycles   = 0;
   int        payload_count = 0;
   int        status_count[7];

   serial_reply_frame_checker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic clear_frame();
      rx_phase     = srfc_pkg::PHASE_HEADER;
      hdr_index    = 0;
      hdr_start    = 8'h00;
      hdr_addr     = 8'h00;
      hdr_cmd      = 8'h00;
      frame_len    = 8'h00;
      payload_left = 8'h00;
      run_xor      = 8'h00;
      run_sum      = 8'h00;
      sum_mismatch = 1'b0;
   endtask

   // Advances the predicted frame state by one received byte and queues the
   // result that byte should cause, if any.
   task automatic predict_reply(input logic [7:0] rx);
      reply_type                  r;
      srfc_pkg::frame_status_type code;
      r.is_status    = 1'b0;
      r.payload_byte = rx;
      r.status       = srfc_pkg::STATUS_OK;
      r.length       = 8'h00;
      case (rx_phase)
         srfc_pkg::PHASE_PAYLOAD: begin
            run_xor ^= rx;
            run_sum += rx;
            payload_left--;
            if (payload_left == 8'h00) rx_phase = srfc_pkg::PHASE_CHECKSUM;
            expected_replies.push_back(r);
         end
         srfc_pkg::PHASE_CHECKSUM: begin
            sum_mismatch = (rx != (run_xor ^ run_sum));
            rx_phase     = srfc_pkg::PHASE_END;
         end
         srfc_pkg::PHASE_END: begin
            // A bad checksum wins over a bad end byte.
            if (sum_mismatch) code = srfc_pkg::STATUS_BAD_SUM;
            else if (rx != srfc_pkg::END_BYTE) code = srfc_pkg::STATUS_BAD_END;
            else code = srfc_pkg::STATUS_OK;
            r.is_status    = 1'b1;
            r.payload_byte = 8'h00;
            r.status       = code;
            r.length       = frame_len;
            expected_replies.push_back(r);
            clear_frame();
         end
         default: begin
            rx_phase = srfc_pkg::PHASE_HEADER;
            run_xor ^= rx;
            run_sum += rx;
            case (hdr_index)
               0: hdr_start = rx;
               1: hdr_addr  = rx;
               2: hdr_cmd   = rx;
               default: ;
            endcase
            if (hdr_index < 3) begin
               hdr_index++;
            end else begin
               // Header complete: only the first failing check is reported.
               hdr_index = 0;
               frame_len = rx;
               if (hdr_start != srfc_pkg::START_BYTE) code = srfc_pkg::STATUS_BAD_START;
               else if (hdr_addr != want_addr) code = srfc_pkg::STATUS_BAD_ADDR;
               else if (hdr_cmd != want_cmd) code = srfc_pkg::STATUS_BAD_CMD;
               else if (rx > len_limit) code = srfc_pkg::STATUS_TOO_LONG;
               else code = srfc_pkg::STATUS_OK;
               if (code != srfc_pkg::STATUS_OK) begin
                  r.is_status    = 1'b1;
                  r.payload_byte = 8'h00;
                  r.status       = code;
                  r.length       = rx;
                  expected_replies.push_back(r);
                  clear_frame();
               end else if (rx == 8'h00) begin
                  rx_phase = srfc_pkg::PHASE_CHECKSUM;
               end else begin
                  payload_left = rx;
                  rx_phase     = srfc_pkg::PHASE_PAYLOAD;
               end
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      rx_pending.push_back(b);
      bytes_queued++;
   endtask

   // Queues one frame; a header_only frame ends after its length byte.
   task automatic queue_frame(input logic [7:0] start_b, input logic [7:0] addr_b,
                              input logic [7:0] cmd_b, input logic [7:0] len_b,
                              input logic header_only, input logic spoil_sum,
                              input logic [7:0] end_b);
      logic [7:0] hdr[4];
      logic [7:0] fold_x;
      logic [7:0] fold_s;
      logic [7:0] b;
      hdr    = '{start_b, addr_b, cmd_b, len_b};
      fold_x = 8'h00;
      fold_s = 8'h00;
      foreach (hdr[i]) begin
         send_byte(hdr[i]);
         fold_x ^= hdr[i];
         fold_s += hdr[i];
      end
      if (!header_only) begin
         for (int i = 0; i < len_b; i++) begin
            b = 8'($urandom);
            send_byte(b);
            fold_x ^= b;
            fold_s += b;
         end
         b = fold_x ^ fold_s;
         if (spoil_sum) b ^= 8'($urandom_range(1, 255));
         send_byte(b);
         send_byte(end_b);
      end
   endtask

   // Mostly well-formed frames with random content, some broken ones and a
   // little line noise that knocks the header out of step.
   task automatic queue_random_frame(input logic [7:0] addr, input logic [7:0] cmd,
                                     input logic [7:0] limit);
      int         pick;
      int         lim;
      logic [7:0] len;
      logic [7:0] flip;
      logic [7:0] junk;
      pick = int'($urandom_range(0, 99));
      lim  = int'(limit);
      flip = 8'($urandom_range(1, 255));
      junk = 8'($urandom);
      if ($urandom_range(0, 49) == 0) len = 8'($urandom_range(0, lim));
      else len = 8'($urandom_range(0, (lim < 12) ? lim : 12));
      if (pick < 60) begin
         queue_frame(srfc_pkg::START_BYTE, addr, cmd, len, 1'b0, 1'b0, srfc_pkg::END_BYTE);
      end else if (pick < 68) begin
         queue_frame(srfc_pkg::START_BYTE, addr, cmd, len, 1'b0, 1'b1,
                     pick[0] ? junk : srfc_pkg::END_BYTE);
      end else if (pick < 76) begin
         queue_frame(srfc_pkg::START_BYTE, addr, cmd, len, 1'b0, 1'b0,
                     srfc_pkg::END_BYTE ^ flip);
      end else if (pick < 80) begin
         queue_frame(srfc_pkg::START_BYTE ^ flip, addr, cmd, junk, 1'b1, 1'b0,
                     srfc_pkg::END_BYTE);
      end else if (pick < 84) begin
         queue_frame(srfc_pkg::START_BYTE, addr ^ flip, cmd, junk, 1'b1, 1'b0,
                     srfc_pkg::END_BYTE);
      end else if (pick < 88) begin
         queue_frame(srfc_pkg::START_BYTE, addr, cmd ^ flip, junk, 1'b1, 1'b0,
                     srfc_pkg::END_BYTE);
      end else if (pick < 94 && lim < 255) begin
         len = 8'($urandom_range(lim + 1, 255));
         queue_frame(srfc_pkg::START_BYTE, addr, cmd, len, 1'b1, 1'b0, srfc_pkg::END_BYTE);
      end else if (pick < 94) begin
         queue_frame(srfc_pkg::START_BYTE, addr, cmd, len, 1'b0, 1'b0, srfc_pkg::END_BYTE);
      end else begin
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
   endtask

   task automatic write_csr(input logic [srfc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued byte is taken and every result has arrived,
   // then lets the last header or checksum byte settle.
   task automatic wait_for_drain();
      do @(negedge clock); while (bytes_taken != bytes_queued || expected_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sender: offers the next pending byte, holding it until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= rx_pending.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold whenever one is requested.
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: tracks register writes, predicts on each taken byte and checks
   // each result item against the oldest expectation.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (reset) begin
         want_addr = srfc_pkg::EXPECTED_ADDRESS_RESET;
         want_cmd  = srfc_pkg::EXPECTED_COMMAND_RESET;
         len_limit = srfc_pkg::MAX_PAYLOAD_LEN_RESET;
         clear_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               srfc_pkg::CSR_EXPECTED_ADDRESS: want_addr = csr_data;
               srfc_pkg::CSR_EXPECTED_COMMAND: want_cmd  = csr_data;
               srfc_pkg::CSR_MAX_PAYLOAD_LEN:  len_limit = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_reply(req_tdata);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: tuser %b tdata %h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               head_reply = expected_replies.pop_front();
               if (head_reply.is_status) status_count[head_reply.status]++;
               else payload_count++;
               if (rsp_tuser[0] !== head_reply.is_status)
                  report_mismatch($sformatf("is_status got %b want %b",
                                            rsp_tuser[0], head_reply.is_status));
               if (rsp_tdata[7:0] !== head_reply.payload_byte)
                  report_mismatch($sformatf("payload_byte got %h want %h",
                                            rsp_tdata[7:0], head_reply.payload_byte));
               if (rsp_tdata[10:8] !== head_reply.status)
                  report_mismatch($sformatf("frame_status got %0d want %0d",
                                            rsp_tdata[10:8], head_reply.status));
               if (rsp_tdata[18:11] !== head_reply.length)
                  report_mismatch($sformatf("payload_len got %h want %h",
                                            rsp_tdata[18:11], head_reply.length));
               if (rsp_tdata[srfc_pkg::RSP_DATA_W-1:19] !== '0)
                  report_mismatch($sformatf("padding bits not zero: tdata %h", rsp_tdata));
            end
         end
         // Watchdog on cycles in which no item moves on any channel.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles with no item moving", idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int budget;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset register values written back; slow receiver.
      send_idle_pct <= 27;
      recv_idle_pct <= 58;
      write_csr(srfc_pkg::CSR_EXPECTED_ADDRESS, 8'h00);
      write_csr(srfc_pkg::CSR_EXPECTED_COMMAND, 8'h01);
      write_csr(srfc_pkg::CSR_MAX_PAYLOAD_LEN, 8'hFF);
      @(posedge clock);
      // Good empty frame, bad start, address and command headers, and bad checksum with bad end.
      queue_frame(srfc_pkg::START_BYTE, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, srfc_pkg::END_BYTE);
      queue_frame(8'h00, 8'h00, 8'h01, 8'hFF, 1'b1, 1'b0, srfc_pkg::END_BYTE);
      queue_frame(srfc_pkg::START_BYTE, 8'hFF, 8'h01, 8'h00, 1'b1, 1'b0, srfc_pkg::END_BYTE);
      queue_frame(srfc_pkg::START_BYTE, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, srfc_pkg::END_BYTE);
      queue_frame(srfc_pkg::START_BYTE, 8'h00, 8'h01, 8'h00, 1'b0, 1'b1, 8'hFF);
      // The longest payload once, then random frames.
      budget = bytes_queued + 330;
      queue_frame(srfc_pkg::START_BYTE, 8'h00, 8'h01, 8'hFF, 1'b0, 1'b0, srfc_pkg::END_BYTE);
      while (bytes_queued < budget) queue_random_frame(8'h00, 8'h01, 8'hFF);
      wait_for_drain();

      // Opposite register extremes; slow sender.
      send_idle_pct <= 58;
      recv_idle_pct <= 27;
      write_csr(srfc_pkg::CSR_EXPECTED_ADDRESS, 8'hFF);
      write_csr(srfc_pkg::CSR_EXPECTED_COMMAND, 8'h00);
      write_csr(srfc_pkg::CSR_MAX_PAYLOAD_LEN, 8'h00);
      @(posedge clock);
      // Lengths just over and far over a zero limit, a bad end byte, a good frame.
      queue_frame(srfc_pkg::START_BYTE, 8'hFF, 8'h00, 8'h01, 1'b1, 1'b0, srfc_pkg::END_BYTE);
      queue_frame(srfc_pkg::START_BYTE, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, srfc_pkg::END_BYTE);
      queue_frame(srfc_pkg::START_BYTE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h0C);
      queue_frame(srfc_pkg::START_BYTE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, srfc_pkg::END_BYTE);
      budget = bytes_queued + 60;
      while (bytes_queued < budget) queue_random_frame(8'hFF, 8'h00, 8'h00);
      wait_for_drain();

      // Random registers, no idling, and one long receiver hold so that the
      // result side backs up and the input stalls.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_csr(srfc_pkg::CSR_EXPECTED_ADDRESS, 8'($urandom));
      write_csr(srfc_pkg::CSR_EXPECTED_COMMAND, 8'($urandom));
      write_csr(srfc_pkg::CSR_MAX_PAYLOAD_LEN, 8'($urandom_range(1, 40)));
      @(posedge clock);
      budget = bytes_queued + 120;
      while (bytes_queued < budget) queue_random_frame(want_addr, want_cmd, len_limit);
      hold_token <= hold_token + 1;
      wait_for_drain();

      if (expected_replies.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
      $display("Covered %0d received bytes: %0d payload items and %0d frame statuses checked,",
                bytes_taken, payload_count, status_count.sum());
      $display("statuses ok/start/addr/cmd/long/sum/end: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                status_count[0], status_count[1], status_count[2], status_count[3],
                status_count[4], status_count[5], status_count[6]);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/srfc_pkg.sv
sv/serial_reply_frame_checker.sv
tb/tb_serial_reply_frame_checker.sv
